[rtl/sv32ptw_pkg.sv]
// Shared types and constants for the Sv32 page table walker.
// No dependencies; imported by sv32ptw_step and sv32_page_table_walker.
package sv32ptw_pkg;

    // Beat kinds on the input channel
    localparam logic KIND_REQ = 1'b0;
    localparam logic KIND_PTE = 1'b1;

    // Result kinds on the output channel
    localparam logic RES_READ = 1'b0;
    localparam logic RES_DONE = 1'b1;

    // Access type codes
    localparam logic [1:0] ACC_FETCH = 2'd0;
    localparam logic [1:0] ACC_LOAD  = 2'd1;
    localparam logic [1:0] ACC_STORE = 2'd2;
    localparam logic [1:0] ACC_RSVD  = 2'd3;   // unused code, no leaf grants it

    // Configuration register indexes
    localparam logic CFG_ENABLE = 1'b0;
    localparam logic CFG_ROOT   = 1'b1;

    localparam int CfgWidth = 22;

    // PTE flag bit positions
    localparam int PTE_V = 0;
    localparam int PTE_R = 1;
    localparam int PTE_W = 2;
    localparam int PTE_X = 3;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_L1   = 2'd1,
        PH_L0   = 2'd2
    } t_phase;

    typedef struct packed {
        logic        result_kind;
        logic [31:0] address;
        logic        fault;
        logic [1:0]  fault_access;
    } t_result;

    typedef struct packed {
        logic    emit;      // beat produces a result
        t_result res;
        t_phase  next_phase;
        logic    save;      // capture vaddr/access of a new walk
    } t_step;

endpackage

[rtl/sv32ptw_step.sv]
// Combinational decision for one input beat of the Sv32 walker.
// Depends on sv32ptw_pkg.
module sv32ptw_step (
    input  logic                   i_kind,
    input  logic [31:0]            i_virt_addr,
    input  logic [1:0]             i_access,
    input  logic [31:0]            i_pte_word,
    input  logic                   i_xlate_en,
    input  logic [21:0]            i_root_page,
    input  sv32ptw_pkg::t_phase    i_phase,
    input  logic [31:0]            i_saved_vaddr,
    input  logic [1:0]             i_saved_access,
    output sv32ptw_pkg::t_step     o_step
);
    import sv32ptw_pkg::*;

    logic        busy;
    logic        pte_v, pte_r, pte_w, pte_x;
    logic [21:0] ppn;
    logic [9:0]  vpn0;
    logic [11:0] offs;
    logic        denies;
    t_result     fault_res;

    assign busy  = (i_phase == PH_L1) || (i_phase == PH_L0);
    assign pte_v = i_pte_word[PTE_V];
    assign pte_r = i_pte_word[PTE_R];
    assign pte_w = i_pte_word[PTE_W];
    assign pte_x = i_pte_word[PTE_X];
    assign ppn   = i_pte_word[31:10];
    assign vpn0  = i_saved_vaddr[21:12];
    assign offs  = i_saved_vaddr[11:0];

    // Leaf permission check against the saved access type
    always_comb begin
        unique case (i_saved_access)
            ACC_FETCH: denies = !pte_x;
            ACC_LOAD:  denies = !pte_r;
            ACC_STORE: denies = !pte_w;
            default:   denies = 1'b1;
        endcase
    end

    assign fault_res = '{result_kind: RES_DONE, address: i_saved_vaddr,
                         fault: 1'b1, fault_access: i_saved_access};

    // Next phase and result
    always_comb begin
        o_step            = '0;
        o_step.next_phase = i_phase;
        if (i_kind == KIND_REQ) begin
            if (!busy) begin
                o_step.emit = 1'b1;
                if (!i_xlate_en) begin
                    o_step.res = '{result_kind: RES_DONE, address: i_virt_addr,
                                   fault: 1'b0, fault_access: i_access};
                end else begin
                    o_step.save       = 1'b1;
                    o_step.next_phase = PH_L1;
                    o_step.res = '{result_kind: RES_READ,
                                   address: {i_root_page[19:0], i_virt_addr[31:22], 2'b00},
                                   fault: 1'b0, fault_access: 2'b00};
                end
            end
        end else if (busy) begin
            o_step.emit       = 1'b1;
            o_step.next_phase = PH_IDLE;
            o_step.res        = fault_res;
            if (pte_v && !(pte_w && !pte_r)) begin
                if (i_phase == PH_L1) begin
                    if (!pte_r && !pte_x) begin
                        // pointer to the level-0 table
                        o_step.next_phase = PH_L0;
                        o_step.res = '{result_kind: RES_READ,
                                       address: {ppn[19:0], vpn0, 2'b00},
                                       fault: 1'b0, fault_access: 2'b00};
                    end else if ((ppn[9:0] == 10'd0) && !denies) begin
                        // superpage leaf
                        o_step.res = '{result_kind: RES_DONE,
                                       address: {ppn[19:10], vpn0, offs},
                                       fault: 1'b0, fault_access: i_saved_access};
                    end
                end else if ((pte_r || pte_x) && !denies) begin
                    o_step.res = '{result_kind: RES_DONE,
                                   address: {ppn[19:0], offs},
                                   fault: 1'b0, fault_access: i_saved_access};
                end
            end
        end
    end

endmodule

[rtl/sv32_page_table_walker.sv]
// Sv32 two-level page table walker, top level.
// The result of an accepted input beat is registered in the output register in the cycle after it is taken.
// Throughput: 1 beat per cycle; the single output register frees as the result is taken.
// Memory latency between a read request and its PTE beat lies outside the block.
// Reset (synchronous, active low): idle phase, translation off, root PPN zero, output empty.
// Depends on sv32ptw_pkg and sv32ptw_step.
module sv32_page_table_walker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [sv32ptw_pkg::CfgWidth-1:0] i_cfg_data,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_kind,
    input  logic [31:0] i_virt_addr,
    input  logic [1:0]  i_access,
    input  logic [31:0] i_pte_word,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_result_kind,
    output logic [31:0] o_address,
    output logic        o_fault,
    output logic [1:0]  o_fault_access
);
    import sv32ptw_pkg::*;

    logic        r_xlate_en;
    logic [21:0] r_root_page;
    t_phase      r_phase;
    t_phase      n_phase;
    logic [31:0] r_saved_vaddr;
    logic [1:0]  r_saved_access;
    logic        r_out_valid;
    t_result     r_out;
    t_step       step;
    logic        accept;

    // Input is taken whenever the output register is empty or draining
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xlate_en  <= 1'b0;
            r_root_page <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ENABLE: r_xlate_en  <= i_cfg_data[0];
                CFG_ROOT:   r_root_page <= i_cfg_data[21:0];
                default:    r_xlate_en  <= r_xlate_en;
            endcase
        end
    end

    sv32ptw_step u_step (
        .i_kind         (i_kind),
        .i_virt_addr    (i_virt_addr),
        .i_access       (i_access),
        .i_pte_word     (i_pte_word),
        .i_xlate_en     (r_xlate_en),
        .i_root_page    (r_root_page),
        .i_phase        (r_phase),
        .i_saved_vaddr  (r_saved_vaddr),
        .i_saved_access (r_saved_access),
        .o_step         (step)
    );

    // Next walk phase
    always_comb begin
        n_phase = r_phase;
        if (accept) begin
            n_phase = step.next_phase;
        end
    end

    // Walk state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_saved_vaddr  <= '0;
            r_saved_access <= '0;
        end else begin
            r_phase <= n_phase;
            if (accept && step.save) begin
                r_saved_vaddr  <= i_virt_addr;
                r_saved_access <= i_access;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= accept && step.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && step.emit) begin
            r_out <= step.res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_kind  = r_out.result_kind;
    assign o_address      = r_out.address;
    assign o_fault        = r_out.fault;
    assign o_fault_access = r_out.fault_access;

endmodule
